### hdl/index_value_table_min_index_lookup_macros.svh
// Assertion macros for the index/value table block.
// No dependencies; included by the top level.
`ifndef INDEX_VALUE_TABLE_MIN_INDEX_LOOKUP_MACROS_SVH
`define INDEX_VALUE_TABLE_MIN_INDEX_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define IVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define IVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ivt_pkg.sv
// Shared constants and controller/datapath interface types for the
// index/value table block. No dependencies.
package ivt_pkg;

  localparam int ENTRIES = 64;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int FIELD_W = 31;

  localparam logic OP_CHANGE = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ivt_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
  } ivt_stat_t;

endpackage

### hdl/index_value_table_min_index_lookup.sv
// Index/value table with smallest-index lookup by number.
// Channels: input (in_valid/in_ready, in_operation, in_slot_key,
// in_stored_number) and result (out_valid/out_ready, out_found,
// out_min_key, out_table_full); each transfer completes when valid and
// ready are both high. Operation change stores a number at an index,
// reusing the slot that holds the index or else the next free slot, and
// flags table_full when no slot is free. Operation find returns the
// smallest index whose number matches, with found low and min_key zero
// on a miss.
// From input transfer to result valid the controller steps through a
// scan over the occupied slots, drain and commit, and the result
// registers load at commit; an empty table goes straight to commit. One
// comparator reads one slot a cycle, and one item is in work at a time.
// Reset empties the table at once (fill count cleared) and drops any
// pending result. A stalled receiver holds the result register; the next
// item is taken and scanned meanwhile, and waits to commit until the
// result register frees.
// Depends on ivt_pkg, ivt_ctrl, ivt_dp and the assertion macro header.
`include "index_value_table_min_index_lookup_macros.svh"

module index_value_table_min_index_lookup
  import ivt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [FIELD_W-1:0] in_slot_key,
  input  logic [FIELD_W-1:0] in_stored_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [FIELD_W-1:0] out_min_key,
  output logic               out_table_full
);

  ivt_cmd_t  cmd;
  ivt_stat_t stat;

  ivt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ivt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_slot_key      (in_slot_key),
    .in_stored_number (in_stored_number),
    .stat             (stat),
    .out_found        (out_found),
    .out_min_key      (out_min_key),
    .out_table_full   (out_table_full)
  );

  `IVT_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "second transfer during scan")
  `IVT_ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid, "commit without result")
  `IVT_ASSERT_NOW(a_excl_flags, clk, rst_n, out_valid, !(out_found && out_table_full), "found and full together")
  `IVT_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_found, out_min_key == '0, "miss with nonzero key")

endmodule

### hdl/ivt_ctrl.sv
// Sequencer for the index/value table: load, scan, drain, commit.
// Depends on ivt_pkg.
module ivt_ctrl
  import ivt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ivt_stat_t stat,
  output ivt_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = in_valid && (state_r == ST_IDLE);
  assign cmd.issue  = (state_r == ST_SCAN);
  assign cmd.commit = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= stat.empty ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.scan_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (cmd.commit) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/ivt_dp.sv
// Datapath for the index/value table: slot memory, fill count, one
// comparator over the scan, result registers. Depends on ivt_pkg.
module ivt_dp
  import ivt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ivt_cmd_t           cmd,
  input  logic               in_operation,
  input  logic [FIELD_W-1:0] in_slot_key,
  input  logic [FIELD_W-1:0] in_stored_number,
  output ivt_stat_t          stat,
  output logic               out_found,
  output logic [FIELD_W-1:0] out_min_key,
  output logic               out_table_full
);

  logic [2*FIELD_W-1:0] mem [ENTRIES];
  logic [2*FIELD_W-1:0] rdata_r;

  logic [CNT_W-1:0]   count_r;
  logic [ADDR_W-1:0]  scan_addr_r;
  logic [ADDR_W-1:0]  cmp_addr_r;
  logic               cmp_valid_r;
  logic               op_r;
  logic [FIELD_W-1:0] key_r;
  logic [FIELD_W-1:0] num_r;
  logic               hit_r;
  logic [ADDR_W-1:0]  hit_addr_r;
  logic [FIELD_W-1:0] best_r;
  logic               found_r;
  logic [FIELD_W-1:0] min_key_r;
  logic               full_r;

  logic [FIELD_W-1:0] rd_index;
  logic [FIELD_W-1:0] rd_number;
  logic               is_full;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;

  assign rd_index  = rdata_r[2*FIELD_W-1:FIELD_W];
  assign rd_number = rdata_r[FIELD_W-1:0];
  assign is_full   = (count_r == CNT_W'(ENTRIES));

  assign stat.empty     = (count_r == '0);
  assign stat.scan_last = ((CNT_W'(scan_addr_r) + CNT_W'(1)) == count_r);

  assign wr_en   = cmd.commit && (op_r == OP_CHANGE) && (hit_r || !is_full);
  assign wr_addr = hit_r ? hit_addr_r : count_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {key_r, num_r};
    end
    rdata_r <= mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      cmp_valid_r <= cmd.issue;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (cmp_valid_r) begin
        if (op_r == OP_CHANGE) begin
          if (rd_index == key_r) begin
            hit_r <= 1'b1;
          end
        end else if (rd_number == num_r) begin
          hit_r <= 1'b1;
        end
      end
      if (wr_en && !hit_r) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_operation;
      key_r       <= in_slot_key;
      num_r       <= in_stored_number;
      scan_addr_r <= '0;
    end else if (cmd.issue) begin
      scan_addr_r <= scan_addr_r + ADDR_W'(1);
    end
    cmp_addr_r <= scan_addr_r;
    if (cmp_valid_r) begin
      if (op_r == OP_CHANGE) begin
        if (rd_index == key_r) begin
          hit_addr_r <= cmp_addr_r;
        end
      end else if ((rd_number == num_r) && (!hit_r || (rd_index < best_r))) begin
        best_r <= rd_index;
      end
    end
    if (cmd.commit) begin
      if (op_r == OP_CHANGE) begin
        found_r   <= 1'b0;
        min_key_r <= '0;
        full_r    <= !hit_r && is_full;
      end else begin
        found_r   <= hit_r;
        min_key_r <= hit_r ? best_r : '0;
        full_r    <= 1'b0;
      end
    end
  end

  assign out_found      = found_r;
  assign out_min_key    = min_key_r;
  assign out_table_full = full_r;

endmodule
